// File: sv/system_tick_housekeeping_top_macros.svh
// ---------------------------------------------------------------------------
// system_tick_housekeeping_top_macros.svh
// Assertion macros used by the tick housekeeping core (sth_core).
// ---------------------------------------------------------------------------
`ifndef SYSTEM_TICK_HOUSEKEEPING_TOP_MACROS_SVH
`define SYSTEM_TICK_HOUSEKEEPING_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked on every clock edge outside reset
`define STH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define STH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STH_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define STH_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/sth_pkg.sv
// ---------------------------------------------------------------------------
// sth_pkg
// Types and constants of the system tick housekeeping block.
// ---------------------------------------------------------------------------
package sth_pkg;

  // Width of the internal tick and USB scan counters
  localparam int TICK_WIDTH    = 32;
  localparam int TICK_OUT_W    = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int KEY_HOLD_W    = 32;

  // Action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_MOTOR = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_VALID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_SEC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USB_PERIOD  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] KEY_VALID_RST   = 16'd50;
  localparam logic [CFG_W-1:0] MOTOR_PULSE_RST = 16'd100;
  localparam logic [CFG_W-1:0] TICKS_SEC_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] TIMER_LIMIT_RST = 16'd30000;
  localparam logic [CFG_W-1:0] USB_PERIOD_RST  = 16'd10;

  // Configuration write transaction
  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_write_t;

  // One input item
  typedef struct packed {
    logic [1:0]  action;
    logic        key_pressed;
    logic        usb_level;
    logic [15:0] pulse_ticks;
  } item_t;

  // One result item
  typedef struct packed {
    logic                  second_event;
    logic                  key_event;
    logic                  motor_drive;
    logic                  usb_absent;
    logic [15:0]           input_timer_value;
    logic [TICK_OUT_W-1:0] tick_value;
  } result_t;

endpackage

// File: sv/sth_core.sv
// ---------------------------------------------------------------------------
// sth_core
// Housekeeping state, configuration registers and the per-item update.
// ---------------------------------------------------------------------------
`include "system_tick_housekeeping_top_macros.svh"

module sth_core (
  input  logic                clk,
  input  logic                rst,
  input  sth_pkg::cfg_write_t cfg_wr,
  input  logic                step,
  input  sth_pkg::item_t      item,
  output sth_pkg::result_t    result
);
  import sth_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] key_valid_ticks;
  logic [CFG_W-1:0] motor_pulse_ticks;
  logic [CFG_W-1:0] ticks_per_second;
  logic [CFG_W-1:0] input_timer_limit;
  logic [CFG_W-1:0] usb_scan_period;

  // State
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [15:0]           second_divider, second_divider_next;
  logic                  timer_running, timer_running_next;
  logic [15:0]           timer_count, timer_count_next;
  logic [15:0]           motor_remaining, motor_remaining_next;
  logic [KEY_HOLD_W-1:0] key_hold_count, key_hold_count_next;
  logic [TICK_WIDTH-1:0] next_usb_scan, next_usb_scan_next;
  logic                  usb_absent_flag, usb_absent_flag_next;

  logic [15:0] div_inc;
  logic [15:0] motor_dec;
  logic        sec;
  logic        kev;

  // Configuration decoder
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid_ticks   <= KEY_VALID_RST;
      motor_pulse_ticks <= MOTOR_PULSE_RST;
      ticks_per_second  <= TICKS_SEC_RST;
      input_timer_limit <= TIMER_LIMIT_RST;
      usb_scan_period   <= USB_PERIOD_RST;
    end else if (cfg_wr.en) begin
      unique case (cfg_wr.index)
        CFG_KEY_VALID:   key_valid_ticks   <= cfg_wr.data;
        CFG_MOTOR_PULSE: motor_pulse_ticks <= cfg_wr.data;
        CFG_TICKS_SEC:   ticks_per_second  <= cfg_wr.data;
        CFG_TIMER_LIMIT: input_timer_limit <= cfg_wr.data;
        CFG_USB_PERIOD:  usb_scan_period   <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign div_inc   = second_divider + 16'd1;
  assign motor_dec = (motor_remaining != 16'd0) ? motor_remaining - 16'd1 : 16'd0;

  // Per-item update
  always_comb begin
    tick_count_next       = tick_count;
    second_divider_next   = second_divider;
    timer_running_next    = timer_running;
    timer_count_next      = timer_count;
    motor_remaining_next  = motor_remaining;
    key_hold_count_next   = key_hold_count;
    next_usb_scan_next    = next_usb_scan;
    usb_absent_flag_next  = usb_absent_flag;
    sec                   = 1'b0;
    kev                   = 1'b0;

    case (item.action)
      ACT_TICK: begin
        tick_count_next = tick_count + TICK_WIDTH'(1);

        // divider stands in for tick % ticks_per_second
        if (div_inc >= ticks_per_second) begin
          second_divider_next = 16'd0;
          sec                 = 1'b1;
        end else begin
          second_divider_next = div_inc;
        end

        if (timer_running) begin
          timer_count_next = (timer_count < input_timer_limit) ?
                             timer_count + 16'd1 : 16'd0;
        end

        motor_remaining_next = motor_dec;

        // key judged on release; a valid press restarts the motor pulse
        if (item.key_pressed) begin
          if (key_hold_count != '1) begin
            key_hold_count_next = key_hold_count + KEY_HOLD_W'(1);
          end
        end else begin
          if (key_hold_count > KEY_HOLD_W'(key_valid_ticks)) begin
            kev                  = 1'b1;
            motor_remaining_next = motor_pulse_ticks;
          end
          key_hold_count_next = '0;
        end

        // USB sample when the tick reaches the scheduled scan point
        if (tick_count_next >= next_usb_scan) begin
          usb_absent_flag_next = ~item.usb_level;
          next_usb_scan_next   = next_usb_scan + TICK_WIDTH'(usb_scan_period);
        end
      end
      ACT_START: begin
        timer_running_next = 1'b1;
        timer_count_next   = 16'd0;
      end
      ACT_STOP: begin
        timer_running_next = 1'b0;
        timer_count_next   = 16'd0;
      end
      default: begin
        motor_remaining_next = item.pulse_ticks;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      second_divider   <= '0;
      timer_running    <= 1'b0;
      timer_count      <= '0;
      motor_remaining  <= '0;
      key_hold_count   <= '0;
      next_usb_scan    <= '0;
      usb_absent_flag  <= 1'b0;
    end else if (step) begin
      tick_count       <= tick_count_next;
      second_divider   <= second_divider_next;
      timer_running    <= timer_running_next;
      timer_count      <= timer_count_next;
      motor_remaining  <= motor_remaining_next;
      key_hold_count   <= key_hold_count_next;
      next_usb_scan    <= next_usb_scan_next;
      usb_absent_flag  <= usb_absent_flag_next;
    end
  end

  // Result for the item being processed
  assign result.second_event      = sec;
  assign result.key_event         = kev;
  assign result.motor_drive       = (motor_remaining_next != 16'd0);
  assign result.usb_absent        = usb_absent_flag_next;
  assign result.input_timer_value = timer_count_next;
  assign result.tick_value        = TICK_OUT_W'(tick_count_next);

  // Checks
  `STH_ASSERT_NEXT(a_sec_clears_div, clk, rst, step && sec, second_divider == 16'd0, "second event left divider nonzero")
  `STH_ASSERT_NEXT(a_non_tick_holds, clk, rst, step && (item.action != ACT_TICK), $stable(tick_count), "non-tick item moved the tick count")
  `STH_ASSERT_NEXT(a_release_clears, clk, rst, step && (item.action == ACT_TICK) && !item.key_pressed, key_hold_count == '0, "key release did not clear hold count")
  `STH_ASSERT_NEXT(a_start_timer, clk, rst, step && (item.action == ACT_START), timer_running && (timer_count == 16'd0), "timer start not applied")
  `STH_ASSERT_IMPL(a_kev_on_tick, clk, rst, kev, item.action == ACT_TICK, "key event on a non-tick item")

endmodule

// File: sv/system_tick_housekeeping_top.sv
// ---------------------------------------------------------------------------
// system_tick_housekeeping_top
// Millisecond tick housekeeping: tick count, second event, input timer,
// motor pulse, key judgement and USB presence sampling.
//
//   channel  handshake                  payload
//   item     item_valid / item_stall    action key_pressed usb_level pulse_ticks
//   result   result_valid / result_stall second_event key_event motor_drive
//                                        usb_absent input_timer_value tick_value
//   config   cfg_valid / cfg_ready      cfg_index cfg_data
//
// One item per cycle sustained while result_stall is low; a result is presented
// once its item has passed the input register and then the result register
// after the state update.
// Reset is synchronous and restores all counters and register defaults.
// A stalled result holds; the input register still takes an item while the
// result register waits, and item_stall rises only when both are occupied.
// Configuration writes are always ready.
// ---------------------------------------------------------------------------
module system_tick_housekeeping_top (
  input  logic                             clk,
  input  logic                             rst,
  // item channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       action,
  input  logic                             key_pressed,
  input  logic                             usb_level,
  input  logic [15:0]                      pulse_ticks,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             second_event,
  output logic                             key_event,
  output logic                             motor_drive,
  output logic                             usb_absent,
  output logic [15:0]                      input_timer_value,
  output logic [sth_pkg::TICK_OUT_W-1:0]   tick_value,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sth_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sth_pkg::CFG_W-1:0]        cfg_data
);
  import sth_pkg::*;

  logic       in_full;
  item_t      in_item;
  logic       res_full;
  result_t    res;
  result_t    core_res;
  logic       res_free;
  logic       step;
  logic       take;
  cfg_write_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Stage handshakes
  assign res_free   = !res_full || !result_stall;
  assign step       = in_full && res_free;
  assign item_stall = in_full && !res_free;
  assign take       = item_valid && !item_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item.action      <= action;
      in_item.key_pressed <= key_pressed;
      in_item.usb_level   <= usb_level;
      in_item.pulse_ticks <= pulse_ticks;
    end
  end

  sth_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .step   (step),
    .item   (in_item),
    .result (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (step) begin
      res_full <= 1'b1;
    end else if (!result_stall) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= core_res;
    end
  end

  assign result_valid      = res_full;
  assign second_event      = res.second_event;
  assign key_event         = res.key_event;
  assign motor_drive       = res.motor_drive;
  assign usb_absent        = res.usb_absent;
  assign input_timer_value = res.input_timer_value;
  assign tick_value        = res.tick_value;

endmodule
